// ===== hw/rtl/odd_even_merge_sorter_assert.svh =====
// Assertion macros for the odd-even merge sorter RTL, used by its top level.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef ODD_EVEN_MERGE_SORTER_ASSERT_SVH
`define ODD_EVEN_MERGE_SORTER_ASSERT_SVH

// A condition that must hold at every clock edge outside reset.
`define OEMS_ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// A condition that, once true, requires another one in the next cycle.
`define OEMS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/oems_pkg.sv =====
// Package for the odd-even merge sorter: constants, controller states and
// the command and status structs between controller and datapath. No dependencies.
package oems_pkg;

  localparam int N_MAX_DEF = 64;
  localparam int VALUE_W   = 32;

  typedef enum logic [3:0] {
    S_COLLECT,
    S_PLOOP,
    S_KLOOP,
    S_JLOOP,
    S_ILOOP,
    S_CMP,
    S_WRHI,
    S_OREAD,
    S_OSHOW
  } state_t;

  typedef struct packed {
    logic store;   // write the incoming value at the fill position
    logic rd_en;   // load both read registers from the two addresses
    logic wr_lo;   // write the high read register to the low address
    logic wr_hi;   // write the low read register to the high address
    logic clear;   // empty the store for the next set
  } cmd_t;

  typedef struct packed {
    logic swap;     // the pair just read is out of order
    logic dropped;  // a value of the open set was dropped
  } status_t;

endpackage

// ===== hw/rtl/oems_in_if.sv =====
// Input channel of the odd-even merge sorter: one value per transaction.
// Depends on oems_pkg for the value width.
interface oems_in_if;
  import oems_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] value;
  logic                      last;

  modport source (output valid, output value, output last, input ready);
  modport sink   (input valid, input value, input last, output ready);
endinterface

// ===== hw/rtl/oems_out_if.sv =====
// Output channel of the odd-even merge sorter: one sorted value per transaction.
// Depends on oems_pkg for the value width.
interface oems_out_if;
  import oems_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] sorted_value;
  logic                      final_res;
  logic                      overflow;

  modport source (output valid, output sorted_value, output final_res, output overflow,
                  input ready);
  modport sink   (input valid, input sorted_value, input final_res, input overflow,
                  output ready);
endinterface

// ===== hw/rtl/oems_datapath.sv =====
// Datapath of the odd-even merge sorter: element memory, fill count,
// drop flag and the compare unit. Depends on oems_pkg.
module oems_datapath #(
  parameter int N_MAX = oems_pkg::N_MAX_DEF,
  localparam int AW   = $clog2(N_MAX),
  localparam int NW   = $clog2(N_MAX + 1)
) (
  input  logic                               clk,
  input  logic                               rst,
  input  oems_pkg::cmd_t                     cmd,
  output oems_pkg::status_t                  status,
  input  logic signed [oems_pkg::VALUE_W-1:0] in_value,
  input  logic [AW-1:0]                      addr_lo,
  input  logic [AW-1:0]                      addr_hi,
  output logic [NW-1:0]                      count,
  output logic signed [oems_pkg::VALUE_W-1:0] rd_value
);
  import oems_pkg::*;

  logic signed [VALUE_W-1:0] mem [N_MAX];
  logic signed [VALUE_W-1:0] rd_a;
  logic signed [VALUE_W-1:0] rd_b;
  logic                      dropped;
  logic                      full;
  logic                      we;
  logic [AW-1:0]             waddr;
  logic signed [VALUE_W-1:0] wdata;

  assign full = (count == NW'(N_MAX));

  always_comb begin
    we    = 1'b0;
    waddr = addr_lo;
    wdata = rd_b;
    if (cmd.store) begin
      we    = !full;
      waddr = count[AW-1:0];
      wdata = in_value;
    end else if (cmd.wr_lo) begin
      we    = 1'b1;
      waddr = addr_lo;
      wdata = rd_b;
    end else if (cmd.wr_hi) begin
      we    = 1'b1;
      waddr = addr_hi;
      wdata = rd_a;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (cmd.rd_en) begin
      rd_a <= mem[addr_lo];
      rd_b <= mem[addr_hi];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      count   <= '0;
      dropped <= 1'b0;
    end else if (cmd.store) begin
      if (full) begin
        dropped <= 1'b1;
      end else begin
        count <= count + NW'(1);
      end
    end
  end

  assign status.swap    = (rd_a > rd_b);
  assign status.dropped = dropped;
  assign rd_value       = rd_a;

endmodule

// ===== hw/rtl/oems_controller.sv =====
// Controller of the odd-even merge sorter: walks the Batcher network loops
// and sequences collection, compare-exchange and output. Depends on oems_pkg.
module oems_controller #(
  parameter int N_MAX = oems_pkg::N_MAX_DEF,
  localparam int AW   = $clog2(N_MAX),
  localparam int NW   = $clog2(N_MAX + 1),
  localparam int CW   = $clog2(N_MAX) + 2
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  input  logic              item_last,
  output logic              item_ready,
  input  logic              result_ready,
  output logic              result_valid,
  output logic              final_res,
  input  logic [NW-1:0]     count,
  input  oems_pkg::status_t status,
  output oems_pkg::cmd_t    cmd,
  output logic [AW-1:0]     addr_lo,
  output logic [AW-1:0]     addr_hi
);
  import oems_pkg::*;

  state_t        state, state_next;
  logic [CW-1:0] p, p_next;
  logic [CW-1:0] k, k_next;
  logic [CW-1:0] j, j_next;
  logic [CW-1:0] i, i_next;
  logic [NW-1:0] oidx, oidx_next;

  logic [CW-1:0] n;
  logic [CW-1:0] ji;
  logic [CW-1:0] jik;
  logic [CW-1:0] blk_mask;
  logic          same_blk;
  logic          is_final;

  assign n        = CW'(count);
  assign ji       = j + i;
  assign jik      = ji + k;
  assign blk_mask = (p + p) - CW'(1);
  // Both indices fall in the same block of size 2p.
  assign same_blk = (((ji ^ jik) & ~blk_mask) == '0);
  assign is_final = ((oidx + NW'(1)) == count);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_COLLECT;
      p     <= '0;
      k     <= '0;
      j     <= '0;
      i     <= '0;
      oidx  <= '0;
    end else begin
      state <= state_next;
      p     <= p_next;
      k     <= k_next;
      j     <= j_next;
      i     <= i_next;
      oidx  <= oidx_next;
    end
  end

  always_comb begin
    state_next   = state;
    p_next       = p;
    k_next       = k;
    j_next       = j;
    i_next       = i;
    oidx_next    = oidx;
    cmd          = '0;
    item_ready   = 1'b0;
    result_valid = 1'b0;
    unique case (state)
      S_COLLECT: begin
        item_ready = 1'b1;
        if (item_valid) begin
          cmd.store = 1'b1;
          if (item_last) begin
            p_next     = CW'(1);
            state_next = S_PLOOP;
          end
        end
      end
      S_PLOOP: begin
        if (p < n) begin
          k_next     = p;
          state_next = S_KLOOP;
        end else begin
          oidx_next  = '0;
          state_next = S_OREAD;
        end
      end
      S_KLOOP: begin
        if (k == '0) begin
          p_next     = p + p;
          state_next = S_PLOOP;
        end else begin
          j_next     = k & (p - CW'(1));
          state_next = S_JLOOP;
        end
      end
      S_JLOOP: begin
        if ((j + k) < n) begin
          i_next     = '0;
          state_next = S_ILOOP;
        end else begin
          k_next     = k >> 1;
          state_next = S_KLOOP;
        end
      end
      S_ILOOP: begin
        if ((i < k) && (jik < n)) begin
          if (same_blk) begin
            cmd.rd_en  = 1'b1;
            state_next = S_CMP;
          end else begin
            i_next = i + CW'(1);
          end
        end else begin
          j_next     = j + k + k;
          state_next = S_JLOOP;
        end
      end
      S_CMP: begin
        if (status.swap) begin
          cmd.wr_lo  = 1'b1;
          state_next = S_WRHI;
        end else begin
          i_next     = i + CW'(1);
          state_next = S_ILOOP;
        end
      end
      S_WRHI: begin
        cmd.wr_hi  = 1'b1;
        i_next     = i + CW'(1);
        state_next = S_ILOOP;
      end
      S_OREAD: begin
        cmd.rd_en  = 1'b1;
        state_next = S_OSHOW;
      end
      S_OSHOW: begin
        result_valid = 1'b1;
        if (result_ready) begin
          if (is_final) begin
            cmd.clear  = 1'b1;
            oidx_next  = '0;
            state_next = S_COLLECT;
          end else begin
            oidx_next  = oidx + NW'(1);
            state_next = S_OREAD;
          end
        end
      end
      default: begin
        state_next = S_COLLECT;
      end
    endcase
  end

  always_comb begin
    if ((state == S_OREAD) || (state == S_OSHOW)) begin
      addr_lo = oidx[AW-1:0];
    end else begin
      addr_lo = ji[AW-1:0];
    end
    addr_hi = jik[AW-1:0];
  end

  assign final_res = is_final;

endmodule

// ===== hw/rtl/odd_even_merge_sorter.sv =====
// Odd-even merge sorter: collects a set, sorts it ascending, emits it in order.
// Collection accepts one value per cycle. Each network compare reads the pair
// (S_ILOOP), compares it (S_CMP) and, when it is swapped, writes the low entry
// and then the high one (S_WRHI). Each result is read (S_OREAD), then shown.
// Reset (rst, synchronous) empties the set; memory contents are not cleared.
`include "odd_even_merge_sorter_assert.svh"

// Top level of the odd-even merge sorter. Uses oems_pkg, the two channel
// interfaces, oems_controller and oems_datapath.
module odd_even_merge_sorter #(
  parameter int N_MAX = oems_pkg::N_MAX_DEF
) (
  input logic        clk,
  input logic        rst,
  oems_in_if.sink    item,
  oems_out_if.source result
);
  import oems_pkg::*;

  localparam int AW = $clog2(N_MAX);
  localparam int NW = $clog2(N_MAX + 1);

  // The controller runs the loops of the Batcher network over one comparator;
  // the datapath keeps the values in a single memory with two read ports and
  // one write port, so a swap writes its two entries in consecutive cycles.
  cmd_t                      cmd;
  status_t                   status;
  logic [AW-1:0]             addr_lo;
  logic [AW-1:0]             addr_hi;
  logic [NW-1:0]             count;
  logic signed [VALUE_W-1:0] rd_value;

  oems_controller #(
    .N_MAX(N_MAX)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item.valid),
    .item_last    (item.last),
    .item_ready   (item.ready),
    .result_ready (result.ready),
    .result_valid (result.valid),
    .final_res    (result.final_res),
    .count        (count),
    .status       (status),
    .cmd          (cmd),
    .addr_lo      (addr_lo),
    .addr_hi      (addr_hi)
  );

  oems_datapath #(
    .N_MAX(N_MAX)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .status   (status),
    .in_value (item.value),
    .addr_lo  (addr_lo),
    .addr_hi  (addr_hi),
    .count    (count),
    .rd_value (rd_value)
  );

  // The result payload holds steady while a transaction waits: the read
  // register and the drop flag only change once the result is taken.
  assign result.sorted_value = rd_value;
  assign result.overflow     = status.dropped;

  // Input and output phases never overlap.
  `OEMS_ASSERT_ALWAYS(a_phase_excl, !(item.ready && result.valid), "input and output overlap")
  // The memory sees at most one write per cycle.
  `OEMS_ASSERT_ALWAYS(a_one_write, $onehot0({cmd.store, cmd.wr_lo, cmd.wr_hi}), "two writes")
  // After the final result is taken the block is ready for a new set.
  `OEMS_ASSERT_NEXT(a_reopen, result.valid && result.ready && result.final_res, item.ready && (count == '0), "set not reopened")

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// Testbench for odd_even_merge_sorter: directed and random sets of values.
// Depends on oems_pkg, oems_in_if, oems_out_if and the sorter RTL.
module tb;
  import oems_pkg::*;

  // Store depth of the sorter as instantiated below (default parameter).
  localparam int STORE_DEPTH = N_MAX_DEF;
  localparam int CLK_HALF    = 4;
  localparam int IDLE_PCT    = 27;
  localparam int RANDOM_ITEMS = 240;
  // Settle time after the last result, in cycles.
  localparam int TAIL_CYCLES = 200;
  // Past this many mismatches the report goes quiet but keeps counting.
  localparam int REPORT_CAP = 100;
  localparam int DIRECTED_ROWS = 20;

  localparam logic signed [VALUE_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;

  // One expected sorted transaction on the result channel.
  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic                      final_res;
    logic                      overflow;
  } sorted_t;

  // One row of the directed table. A pinned row is a set of one value, so the
  // expected result is that value itself, closing the set, with no overflow.
  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic                      last;
    logic                      pinned;
  } stim_row_t;

  logic clk;
  logic rst;

  oems_in_if  in_ch ();
  oems_out_if out_ch ();

  odd_even_merge_sorter dut (
    .clk   (clk),
    .rst   (rst),
    .item  (in_ch),
    .result(out_ch)
  );

  // Shadow of the sorter's state: the open set as it arrived, how many values
  // it holds, and whether any value of it was dropped for lack of room.
  logic signed [VALUE_W-1:0] held_values [STORE_DEPTH];
  int                        held_count;
  logic                      held_dropped;

  // Sorted results that the sorter still owes, oldest first.
  sorted_t pending_sorted [$];
  int      mismatch_count;

  // While calm is high neither side idles.
  logic calm;

  stim_row_t directed_rows [DIRECTED_ROWS];

  initial begin
    clk = 1'b0;
    forever #(CLK_HALF) clk = ~clk;
  end

  // Hard limit on the run, far beyond the slowest correct run.
  initial begin
    #(8_000_000);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  task automatic report_mismatch(input string what);
    if (mismatch_count < REPORT_CAP) begin
      $display("%0t ns: %s", $time, what);
    end
    mismatch_count++;
  endtask

  // Tracks one accepted input transaction. When it closes the set, the held
  // values are put through the same odd-even merge network as the block and
  // one expected transaction per stored value is queued. A value that arrives
  // with the store full is dropped, even when it closes the set, and marks
  // every result of that set with overflow.
  function automatic void absorb_value(input logic signed [VALUE_W-1:0] v,
                                       input logic closes);
    int p, k, j, i, idx;
    logic signed [VALUE_W-1:0] tmp;
    sorted_t r;
    if (held_count < STORE_DEPTH) begin
      held_values[held_count] = v;
      held_count++;
    end else begin
      held_dropped = 1'b1;
    end
    if (closes) begin
      // Non-recursive Batcher network: p is the size of the merged runs, k
      // the compare distance; pairs that straddle two merge blocks are skipped.
      for (p = 1; p < held_count; p += p) begin
        for (k = p; k > 0; k /= 2) begin
          for (j = k % p; j + k < held_count; j += k + k) begin
            for (i = 0; i < k && j + i + k < held_count; i++) begin
              if ((j + i) / (p + p) == (j + i + k) / (p + p) &&
                  held_values[j + i] > held_values[j + i + k]) begin
                tmp = held_values[j + i];
                held_values[j + i] = held_values[j + i + k];
                held_values[j + i + k] = tmp;
              end
            end
          end
        end
      end
      for (idx = 0; idx < held_count; idx++) begin
        r.value     = held_values[idx];
        r.final_res = (idx == held_count - 1);
        r.overflow  = held_dropped;
        pending_sorted.insert(pending_sorted.size(), r);
      end
      held_count   = 0;
      held_dropped = 1'b0;
    end
  endfunction

  // Values are drawn from the full range, from a narrow band around zero so
  // that equal values are common, and from the extremes of the field.
  function automatic logic signed [VALUE_W-1:0] pick_value();
    logic signed [VALUE_W-1:0] v;
    case ($urandom_range(9))
      0: begin
        case ($urandom_range(3))
          0: v = VAL_MAX;
          1: v = VAL_MIN;
          2: v = '0;
          default: v = -1;
        endcase
      end
      1, 2, 3: v = int'($urandom_range(8)) - 4;
      default: v = $urandom;
    endcase
    return v;
  endfunction

  // Offers one value on the input channel and waits for the handshake. The
  // valid line is left high on return, so the next call either replaces the
  // payload in the same step or lowers valid for an idle cycle.
  task automatic send_item(input logic signed [VALUE_W-1:0] v, input logic closes);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.value <= v;
    in_ch.last  <= closes;
    do @(posedge clk); while (!in_ch.ready);
    absorb_value(v, closes);
  endtask

  // Holds the input channel quiet until every owed result has come back.
  task automatic wait_for_sorted_drain();
    in_ch.valid <= 1'b0;
    while (pending_sorted.size() != 0) @(posedge clk);
  endtask

  // The receiver stalls at random except during the calm stretch.
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Every accepted result transaction is checked against the oldest owed one.
  always @(posedge clk) begin
    sorted_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (pending_sorted.size() == 0) begin
        report_mismatch($sformatf("unexpected result value=%0d final=%0b overflow=%0b",
                                  out_ch.sorted_value, out_ch.final_res,
                                  out_ch.overflow));
      end else begin
        want = pending_sorted.pop_front();
        if (out_ch.sorted_value !== want.value) begin
          report_mismatch($sformatf("sorted_value %0d, expected %0d",
                                    out_ch.sorted_value, want.value));
        end
        if (out_ch.final_res !== want.final_res) begin
          report_mismatch($sformatf("final_res %0b, expected %0b (value %0d)",
                                    out_ch.final_res, want.final_res, want.value));
        end
        if (out_ch.overflow !== want.overflow) begin
          report_mismatch($sformatf("overflow %0b, expected %0b (value %0d)",
                                    out_ch.overflow, want.overflow, want.value));
        end
      end
    end
  end

  initial begin
    int row, n, set_size, set_idx, random_items;
    sorted_t pinned_res;

    rst            <= 1'b1;
    calm           <= 1'b0;
    in_ch.valid    <= 1'b0;
    in_ch.value    <= '0;
    in_ch.last     <= 1'b0;
    held_count     = 0;
    held_dropped   = 1'b0;
    mismatch_count = 0;

    // Directed sets: single values at the extremes pass straight through, then
    // mixed signs with both extremes, duplicates, a descending run of odd
    // length, alternating bit patterns and an already ordered pair.
    directed_rows = '{
      '{VAL_MAX, 1'b1, 1'b1},
      '{VAL_MIN, 1'b1, 1'b1},
      '{32'sd0,  1'b1, 1'b1},
      '{-32'sd1, 1'b1, 1'b1},
      '{32'sd5,  1'b0, 1'b0},
      '{-32'sd1, 1'b0, 1'b0},
      '{VAL_MAX, 1'b0, 1'b0},
      '{VAL_MIN, 1'b1, 1'b0},
      '{32'sd7,  1'b0, 1'b0},
      '{-32'sd3, 1'b0, 1'b0},
      '{32'sd7,  1'b0, 1'b0},
      '{32'sd7,  1'b0, 1'b0},
      '{-32'sd3, 1'b1, 1'b0},
      '{32'sd30, 1'b0, 1'b0},
      '{32'sd20, 1'b0, 1'b0},
      '{32'sd10, 1'b1, 1'b0},
      '{32'sh5555_5555, 1'b0, 1'b0},
      '{32'shAAAA_AAAA, 1'b1, 1'b0},
      '{32'sd1,  1'b0, 1'b0},
      '{32'sd2,  1'b1, 1'b0}
    };

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (row = 0; row < DIRECTED_ROWS; row++) begin
      send_item(directed_rows[row].value, directed_rows[row].last);
      if (directed_rows[row].pinned) begin
        // Replace the predicted transaction with the one read off the table.
        void'(pending_sorted.pop_back());
        pinned_res.value     = directed_rows[row].value;
        pinned_res.final_res = 1'b1;
        pinned_res.overflow  = 1'b0;
        pending_sorted.insert(pending_sorted.size(), pinned_res);
      end
    end
    wait_for_sorted_drain();

    // Random sets. The first fills the store exactly, the second overruns it
    // so that values are dropped both before and at the closing transaction.
    // Later sets are mostly short, with an occasional one near capacity.
    set_idx      = 0;
    random_items = 0;
    while (random_items < RANDOM_ITEMS) begin
      if (set_idx == 0) begin
        set_size = STORE_DEPTH;
      end else if (set_idx == 1) begin
        set_size = STORE_DEPTH + 3;
      end else if ($urandom_range(19) == 0) begin
        set_size = $urandom_range(STORE_DEPTH + 4, STORE_DEPTH - 2);
      end else begin
        set_size = $urandom_range(12, 1);
      end
      // A stretch of sets with back-to-back traffic on both channels.
      calm <= (set_idx >= 6 && set_idx < 16);
      for (n = 0; n < set_size; n++) begin
        send_item(pick_value(), n == set_size - 1);
      end
      random_items += set_size;
      if ($urandom_range(7) == 0) begin
        wait_for_sorted_drain();
      end
      set_idx++;
    end

    wait_for_sorted_drain();
    calm <= 1'b0;
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
